[hw/rtl/fmpd_pkg.sv]
// Shared widths, types and the arctangent table of the FM phase discriminator.
package fmpd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W = 2 * SAMPLE_W + 1;
  localparam int VEC_W = PROD_W + 3;
  localparam int ANG_W = 34;
  localparam int PHASE_W = 16;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_DEPTH = 24;
  localparam int ITER_CNT = (CORDIC_ITERATIONS < ATAN_DEPTH) ? CORDIC_ITERATIONS : ATAN_DEPTH;
  localparam int KW = $clog2(ATAN_DEPTH);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int MAX_INFLIGHT = FIFO_DEPTH + 3;

  // Angle units are pi / 2^31; Q15 output is the angle shifted down by 16.
  localparam int ANG_TO_Q15_SHIFT = 16;

  localparam logic signed [ANG_W-1:0] HALF_PI = ANG_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] ANG_MIN = ANG_W'(-64'sd2147483648);
  localparam logic signed [ANG_W-1:0] TRUNC_ADJ = ANG_W'((64'sd1 <<< ANG_TO_Q15_SHIFT) - 1);

  localparam logic signed [PHASE_W-1:0] PHASE_MAX = 16'sd32767;
  localparam logic signed [PHASE_W-1:0] PHASE_QUARTER = 16'sd16384;
  localparam logic signed [PHASE_W-1:0] PHASE_ZERO = 16'sd0;

  typedef struct packed {
    logic signed [PROD_W-1:0] re;
    logic signed [PROD_W-1:0] im;
    logic                     last;
  } vec_entry_t;

  // atan(2^-k) in units of pi / 2^31, rounded
  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [KW-1:0] k);
    logic signed [ANG_W-1:0] v;
    case (k)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;
      5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;
      5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;
      5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/fmpd_if.sv]
// Request channel interfaces for samples in and phase steps out.
interface fmpd_in_if import fmpd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] i_sample;
  logic signed [SAMPLE_W-1:0] q_sample;
  logic                       last_in;

  modport source (output valid, i_sample, q_sample, last_in, input ready);
  modport sink (input valid, i_sample, q_sample, last_in, output ready);
endinterface

interface fmpd_out_if import fmpd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PHASE_W-1:0] phase_step;
  logic                      last_out;

  modport source (output valid, phase_step, last_out, input ready);
  modport sink (input valid, phase_step, last_out, output ready);
endinterface

[hw/rtl/fmpd_front.sv]
// Front end: accepts samples, forms the conjugate product with the previous sample.
module fmpd_front import fmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fmpd_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       q_push,
  output vec_entry_t q_wdata
);

  logic signed [SAMPLE_W-1:0] prev_i_r, prev_q_r;
  logic signed [2*SAMPLE_W-1:0] p_ii_r, p_qq_r, p_qi_r, p_iq_r;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_last_r;
  logic accept;

  assign q_push = s1_valid_r && !q_full;
  assign in_ch.ready = !s1_valid_r || !q_full;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // re = i*pi + q*pq, im = q*pi - i*pq, one bit of growth each
  assign q_wdata.re = {p_ii_r[2*SAMPLE_W-1], p_ii_r} + {p_qq_r[2*SAMPLE_W-1], p_qq_r};
  assign q_wdata.im = {p_qi_r[2*SAMPLE_W-1], p_qi_r} - {p_iq_r[2*SAMPLE_W-1], p_iq_r};
  assign q_wdata.last = s1_last_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      p_ii_r <= in_ch.i_sample * prev_i_r;
      p_qq_r <= in_ch.q_sample * prev_q_r;
      p_qi_r <= in_ch.q_sample * prev_i_r;
      p_iq_r <= in_ch.i_sample * prev_q_r;
      s1_last_r <= in_ch.last_in;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      prev_i_r <= '0;
      prev_q_r <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        prev_i_r <= in_ch.i_sample;
        prev_q_r <= in_ch.q_sample;
      end
    end
  end

endmodule

[hw/rtl/fmpd_fifo.sv]
// Short queue of product vectors between the front end and the CORDIC engine.
module fmpd_fifo import fmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  vec_entry_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output vec_entry_t rdata
);

  vec_entry_t mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/fmpd_cordic.sv]
// Back end: iterative CORDIC vectoring atan2 and the Q15 output register.
module fmpd_cordic import fmpd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  vec_entry_t                q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [PHASE_W-1:0] phase_step,
  output logic                      last_out
);

  typedef enum logic [1:0] {S_IDLE, S_ITER, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic signed [VEC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic spec_r, spec_nxt;
  logic signed [PHASE_W-1:0] spec_val_r, spec_val_nxt;
  logic last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [PHASE_W-1:0] phase_r, phase_nxt;
  logic last_out_r, last_out_nxt;

  logic signed [VEC_W-1:0] re_ext, im_ext, dx, dy;
  logic signed [ANG_W-1:0] z_clamp, z_q15;
  logic signed [PHASE_W-1:0] z_phase;

  assign re_ext = {{(VEC_W-PROD_W){q_rdata.re[PROD_W-1]}}, q_rdata.re};
  assign im_ext = {{(VEC_W-PROD_W){q_rdata.im[PROD_W-1]}}, q_rdata.im};
  assign dx = y_r >>> k_r;
  assign dy = x_r >>> k_r;
  assign q_pop = (state_r == S_IDLE) && q_not_empty;

  // Clamp to +/-pi, divide toward zero, saturate +pi to the Q15 maximum
  always_comb begin
    if (z_r > ANG_MAX) begin
      z_clamp = ANG_MAX;
    end else if (z_r < ANG_MIN) begin
      z_clamp = ANG_MIN;
    end else begin
      z_clamp = z_r;
    end
    if (z_clamp[ANG_W-1]) begin
      z_q15 = (z_clamp + TRUNC_ADJ) >>> ANG_TO_Q15_SHIFT;
    end else begin
      z_q15 = z_clamp >>> ANG_TO_Q15_SHIFT;
    end
    if (z_q15 > ANG_W'(PHASE_MAX)) begin
      z_phase = PHASE_MAX;
    end else begin
      z_phase = z_q15[PHASE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    k_nxt = k_r;
    spec_nxt = spec_r;
    spec_val_nxt = spec_val_r;
    last_nxt = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    phase_nxt = phase_r;
    last_out_nxt = last_out_r;
    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          last_nxt = q_rdata.last;
          k_nxt = '0;
          spec_nxt = 1'b0;
          spec_val_nxt = PHASE_ZERO;
          if (q_rdata.im == '0) begin
            // real axis: zero or +pi
            spec_nxt = 1'b1;
            spec_val_nxt = q_rdata.re[PROD_W-1] ? PHASE_MAX : PHASE_ZERO;
            state_nxt = S_FIN;
          end else if (q_rdata.re == '0) begin
            spec_nxt = 1'b1;
            spec_val_nxt = q_rdata.im[PROD_W-1] ? -PHASE_QUARTER : PHASE_QUARTER;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_ITER;
            if (q_rdata.re[PROD_W-1]) begin
              // left half plane: turn by 90 degrees first
              if (!q_rdata.im[PROD_W-1]) begin
                x_nxt = im_ext;
                y_nxt = -re_ext;
                z_nxt = HALF_PI;
              end else begin
                x_nxt = -im_ext;
                y_nxt = re_ext;
                z_nxt = -HALF_PI;
              end
            end else begin
              x_nxt = re_ext;
              y_nxt = im_ext;
              z_nxt = '0;
            end
          end
        end
      end
      S_ITER: begin
        if (!y_r[VEC_W-1]) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_lut(k_r);
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_lut(k_r);
        end
        if (k_r == KW'(ITER_CNT - 1)) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          phase_nxt = spec_r ? spec_val_r : z_phase;
          last_out_nxt = last_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    k_r <= k_nxt;
    spec_r <= spec_nxt;
    spec_val_r <= spec_val_nxt;
    last_r <= last_nxt;
    phase_r <= phase_nxt;
    last_out_r <= last_out_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign phase_step = phase_r;
  assign last_out = last_out_r;

endmodule

[hw/rtl/fm_phase_discriminator.sv]
// FM phase discriminator: conjugate product of successive samples and CORDIC atan2.
//
// Channels: in_ch takes one complex Q15 sample (i_sample, q_sample) with an
// end-of-block mark last_in; out_ch returns one Q15 phase step per sample,
// with +pi at 32767, and last_out copied from last_in. Both are valid/ready
// requests taken on a rising edge with valid and ready high.
// Front end: registers the four products against the previous sample, then
// writes re/im from them into a 4-entry queue. The front end takes a new
// request every cycle while the queue has room.
// Back end: the CORDIC engine shares one shift-add stage over
// CORDIC_ITERATIONS steps; each item passes a load state, the steps and an
// output write, and the engine pops no new item from the queue until the
// last one is written out. Items on the real or imaginary axis skip the
// steps. From accept, an item passes the product register, the queue, the
// engine and the output register.
// Reset (synchronous, active low) clears the previous sample to zero, so the
// first result after reset is 0, and empties the queue and output register.
// A stalled receiver holds the output register; the engine and then the
// queue fill behind it, and in_ch.ready drops once seven requests are held.
module fm_phase_discriminator import fmpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fmpd_in_if.sink    in_ch,
  fmpd_out_if.source out_ch
);

  logic q_full, q_push, q_pop, q_not_empty;
  vec_entry_t q_wdata, q_rdata;

  fmpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  fmpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  fmpd_cordic u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .phase_step  (out_ch.phase_step),
    .last_out    (out_ch.last_out)
  );

endmodule

[hw/rtl/fmpd_checker.sv]
// Port-level assertions for the FM phase discriminator, bound to the top level.
module fmpd_checker import fmpd_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [PHASE_W-1:0] phase_step,
  input logic                      last_out
);

  localparam int CW = $clog2(MAX_INFLIGHT + 2);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic first_r;
  logic in_acc, out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      first_r <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      if (out_acc) begin
        first_r <= 1'b0;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(phase_step) && $stable(last_out))
    else $error("out payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result without a pending request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_INFLIGHT))
    else $error("more requests held than the pipeline can store");

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |-> phase_step == PHASE_ZERO)
    else $error("first result after reset is not zero");

endmodule

bind fm_phase_discriminator fmpd_checker u_fmpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .phase_step (out_ch.phase_step),
  .last_out   (out_ch.last_out)
);

[test/fm_phase_discriminator_tb.sv]
// Testbench for the FM phase discriminator: predicted phase steps checked under stalls.
`timescale 1ns / 100ps

module fm_phase_discriminator_tb;
  import fmpd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PRINTED = 200;
  localparam longint RIGHT_ANGLE = 64'sd1073741824;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam real PI = 3.14159265358979;

  typedef struct {
    logic signed [PHASE_W-1:0] phase;
    logic                      last;
  } phase_result_t;

  logic clk;
  logic rst_n;

  fmpd_in_if  in_ch ();
  fmpd_out_if out_ch ();

  fm_phase_discriminator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // atan(2^-k) in units of pi / 2^31
  longint atan_units [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  phase_result_t phase_steps_due[$];
  logic signed [SAMPLE_W-1:0] held_i;
  logic signed [SAMPLE_W-1:0] held_q;
  logic signed [SAMPLE_W-1:0] sent_i;
  logic signed [SAMPLE_W-1:0] sent_q;

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_cycles;
  int error_count;
  int samples_sent;
  int directed_sent;
  int results_checked;
  int input_stall_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Timeout at %0t with %0d results pending", $time, phase_steps_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  // Angle of (x, y) in Q15 of pi, by quadrant fold and shift-add vectoring.
  function automatic logic signed [PHASE_W-1:0] cordic_phase_q15(input longint x,
                                                                  input longint y);
    longint z;
    longint t;
    longint dx;
    longint dy;
    int k;
    z = 0;
    if (y == 0) return (x < 0) ? PHASE_MAX : PHASE_ZERO;
    if (x == 0) return (y > 0) ? PHASE_QUARTER : -PHASE_QUARTER;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = RIGHT_ANGLE;
      end else begin
        x = -y;
        y = t;
        z = -RIGHT_ANGLE;
      end
    end
    for (k = 0; k < ITER_CNT; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_units[k];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_units[k];
      end
    end
    if (z > HALF_TURN) z = HALF_TURN;
    if (z < -HALF_TURN) z = -HALF_TURN;
    z = z / 65536;
    if (z > 32767) z = 32767;
    return PHASE_W'(z);
  endfunction

  // Conjugate product against the held sample, then advance the held sample.
  task automatic predict_phase_step(input logic signed [SAMPLE_W-1:0] s_i,
                                    input logic signed [SAMPLE_W-1:0] s_q,
                                    input logic last);
    longint re;
    longint im;
    phase_result_t r;
    re = longint'(s_i) * longint'(held_i) + longint'(s_q) * longint'(held_q);
    im = longint'(s_q) * longint'(held_i) - longint'(s_i) * longint'(held_q);
    r.phase = cordic_phase_q15(re, im);
    r.last = last;
    phase_steps_due.push_back(r);
    held_i = s_i;
    held_q = s_q;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s_i,
                             input logic signed [SAMPLE_W-1:0] s_q,
                             input logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.i_sample = s_i;
    in_ch.q_sample = s_q;
    in_ch.last_in = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_phase_step(s_i, s_q, last);
    sent_i = s_i;
    sent_q = s_q;
    samples_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (phase_steps_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] to_q15(input real r);
    if (r >= 32767.0) return 16'sh7fff;
    if (r <= -32768.0) return 16'sh8000;
    return SAMPLE_W'($rtoi(r + ((r >= 0.0) ? 0.5 : -0.5)));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] corner_value();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'sh0001;
      default: return 16'shffff;
    endcase
  endfunction

  // Rotating phasor of constant amplitude: a block of FM baseband.
  task automatic send_tone(input int len);
    real amp;
    real ph;
    real dph;
    int n;
    case ($urandom_range(5))
      0: amp = 32767.0 + $urandom_range(1000);
      1: amp = $urandom_range(1, 40);
      default: amp = $urandom_range(1, 32767);
    endcase
    if ($urandom_range(9) == 0) dph = 0.0;
    else dph = (real'($urandom_range(2000)) - 1000.0) / 1000.0 * PI;
    ph = real'($urandom_range(6283)) / 1000.0;
    for (n = 0; n < len; n++) begin
      send_sample(to_q15(amp * $cos(ph)), to_q15(amp * $sin(ph)), n == len - 1);
      ph = ph + dph;
    end
  endtask

  task automatic send_noise(input int len);
    logic signed [SAMPLE_W-1:0] s_i;
    logic signed [SAMPLE_W-1:0] s_q;
    int n;
    for (n = 0; n < len; n++) begin
      case ($urandom_range(5))
        0: begin
          s_i = 16'sh0000;
          s_q = 16'sh0000;
        end
        1: begin
          s_i = sent_i;
          s_q = sent_q;
        end
        2: begin
          s_i = -sent_i;
          s_q = -sent_q;
        end
        3: begin
          s_i = -sent_q;
          s_q = sent_i;
        end
        4: begin
          s_i = corner_value();
          s_q = corner_value();
        end
        default: begin
          s_i = SAMPLE_W'($urandom());
          s_q = SAMPLE_W'($urandom());
        end
      endcase
      send_sample(s_i, s_q, $urandom_range(7) == 0);
    end
  endtask

  task automatic send_random_stream(input int count);
    int start;
    start = samples_sent;
    while (samples_sent - start < count) begin
      if ($urandom_range(99) < 65) send_tone($urandom_range(4, 40));
      else send_noise($urandom_range(1, 8));
    end
  endtask

  task automatic test_axes_and_extremes();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_sample(16'sh7fff, 16'sh7fff, 1'b0);   // first after reset: zero product
    send_sample(16'sh7fff, 16'sh7fff, 1'b0);   // positive real axis
    send_sample(16'sh8000, 16'sh8000, 1'b0);   // negative real axis
    send_sample(16'sh8000, 16'sh8000, 1'b1);   // largest real part
    send_sample(16'sh8000, 16'sh0000, 1'b0);
    send_sample(16'sh0000, 16'sh8000, 1'b0);
    send_sample(16'sh7fff, 16'sh0000, 1'b0);
    send_sample(16'sh0000, 16'sh7fff, 1'b0);   // quarter turn up
    send_sample(16'sh7fff, 16'sh0000, 1'b0);   // quarter turn down
    send_sample(16'sh0000, 16'sh0000, 1'b1);   // zero sample
    send_sample(16'sh0001, 16'sh0000, 1'b0);   // zero held sample
    send_sample(16'sh0001, 16'sh0000, 1'b0);
    send_sample(16'shffff, 16'sh0001, 1'b0);
    send_sample(16'shffff, 16'shffff, 1'b0);
    send_sample(16'shffff, 16'sh0000, 1'b0);
    send_sample(16'sh7fff, 16'sh0001, 1'b0);   // just above -pi
    send_sample(16'sh8000, 16'sh0000, 1'b0);   // just below +pi
    send_sample(16'sh7fff, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b1);
    send_sample(16'sh3039, 16'sha460, 1'b0);
    send_sample(16'sha460, 16'shcfc7, 1'b1);
    directed_sent = samples_sent;
    wait_drained();
  endtask

  task automatic test_streaming();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_random_stream(200);
    wait_drained();
  endtask

  task automatic test_sender_gaps();
    tx_idle_pct = 72;
    rx_stall_pct = 0;
    send_random_stream(200);
    wait_drained();
  endtask

  task automatic test_receiver_stalls();
    tx_idle_pct = 0;
    rx_stall_pct = 72;
    send_random_stream(200);
    wait_drained();
  endtask

  task automatic test_both_idle();
    tx_idle_pct = 31;
    rx_stall_pct = 31;
    send_random_stream(200);
    wait_drained();
  endtask

  // Hold the receiver off long enough that the queue fills and input stalls.
  task automatic test_input_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(posedge clk);
    hold_cycles = HOLD_OFF_CYCLES;
    send_random_stream(40);
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) input_stall_cycles++;
  end

  always @(posedge clk) begin : check_phase_steps
    phase_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (phase_steps_due.size() == 0) begin
        report_error($sformatf("phase step %0d with no request pending", out_ch.phase_step));
      end else begin
        want = phase_steps_due.pop_front();
        if (out_ch.phase_step !== want.phase)
          report_error($sformatf("phase_step got %0d want %0d", out_ch.phase_step, want.phase));
        if (out_ch.last_out !== want.last)
          report_error($sformatf("last_out got %b want %b", out_ch.last_out, want.last));
        results_checked++;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.i_sample = '0;
    in_ch.q_sample = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
    held_i = '0;
    held_q = '0;
    sent_i = '0;
    sent_q = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    samples_sent = 0;
    directed_sent = 0;
    results_checked = 0;
    input_stall_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_axes_and_extremes();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_input_backpressure();

    if (phase_steps_due.size() != 0)
      report_error($sformatf("%0d phase steps never arrived", phase_steps_due.size()));
    $display("Covered %0d samples (%0d directed axis and extreme cases), %0d phase steps checked",
             samples_sent, directed_sent, results_checked);
    $display("Idle mixes: none, sender, receiver, both; input held off %0d cycles",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
